/* design/sdens_pkg.sv */
package sdens_pkg;

  // Largest number of points emitted for one segment
  localparam int SDENS_MAX_POINTS = 64;

  // Spacing register after reset, about 0.05 m in Q16.16
  localparam logic [30:0] SDENS_SPACING_RESET = 31'd3277;

  // Width of the shared add/subtract unit
  localparam int SDENS_ALU_W = 67;

  // Iterations of every bit-serial pass (square, root, divide)
  localparam int SDENS_ITER = 33;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DX,
    ST_AX,
    ST_DY,
    ST_AY,
    ST_SQX,
    ST_SQY,
    ST_ROOT,
    ST_DIVC,
    ST_COUNT,
    ST_DIVX,
    ST_SIGNX,
    ST_DIVY,
    ST_SIGNY,
    ST_EMIT
  } state_t;

endpackage

/* design/sdens_addsub.sv */
module sdens_addsub
  import sdens_pkg::*;
#(
  parameter int W = SDENS_ALU_W
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic         sub,
  output logic [W-1:0] sum,
  output logic         cout
);

  logic [W:0] full;

  // Add, or subtract by inverting b and carrying in; then carry out means a >= b
  always_comb begin
    full = {1'b0, a} + {1'b0, (sub ? ~b : b)} + (W+1)'(sub);
    sum  = full[W-1:0];
    cout = full[W];
  end

endmodule

/* design/segment_point_densifier_unit.sv */
// Segment point densifier.
// in_*  : one segment per request (start and end point, signed Q16.16).
//         Taken when in_valid is high and in_stall is low; in_stall is high
//         whenever a segment is in work, so one segment is processed at a time.
// out_* : one request per emitted point, with its index, a last marker and a
//         saturation flag. The receiver holds back a point with out_stall;
//         the output register then keeps the point and the walk pauses.
// cfg_* : write of the spacing register, taken when cfg_valid and cfg_ready
//         are high; cfg_ready is high while no segment is in work.
// Sequence: a single 67-bit add/subtract unit serves every pass but the count
// and the walk. It forms the differences and magnitudes, then each square, the
// square root and the count division, then each step division with its sign
// fix-up. Points then reach the output register one per cycle unless out_stall
// holds them. The next segment is taken on the cycle after the last point is
// loaded; a zero-length segment returns to idle from the count step with no points.
// Reset (rst_n low, synchronous) returns to idle with no point pending and
// the spacing register at 3277.
module segment_point_densifier_unit
  import sdens_pkg::*;
#(
  parameter int MAX_POINTS = SDENS_MAX_POINTS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_start_x,
  input  logic signed [31:0] in_start_y,
  input  logic signed [31:0] in_end_x,
  input  logic signed [31:0] in_end_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_point_x,
  output logic signed [31:0] out_point_y,
  output logic [5:0]         out_point_index,
  output logic               out_last_point,
  output logic               out_count_clipped,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [30:0]        cfg_spacing
);

  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int AW = SDENS_ALU_W;
  localparam logic [32:0] MAXQ = 33'(MAX_POINTS);
  localparam logic [5:0] ITER_LAST = 6'(SDENS_ITER - 1);

  state_t state_r, state_nxt;

  logic [30:0]        spacing_r;
  logic [31:0]        sx_r, sy_r, ex_r, ey_r;
  logic [31:0]        sx_nxt, sy_nxt, ex_nxt, ey_nxt;
  logic [32:0]        ax_r, ay_r, ax_nxt, ay_nxt;
  logic               xneg_r, yneg_r, xneg_nxt, yneg_nxt;
  logic [65:0]        acc_r, acc_nxt;
  logic [65:0]        mcand_r, mcand_nxt;
  logic [32:0]        mpl_r, mpl_nxt;
  logic [34:0]        rem_r, rem_nxt;
  logic [32:0]        root_r, root_nxt;
  logic               exact_r, exact_nxt;
  logic [5:0]         cnt_r, cnt_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [CW-1:0]      left_r, left_nxt;
  logic [5:0]         idx_r, idx_nxt;
  logic               clip_r, clip_nxt;
  logic [31:0]        walk_x_r, walk_y_r, walk_x_nxt, walk_y_nxt;
  logic [31:0]        step_x_r, step_y_r, step_x_nxt, step_y_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [31:0]        out_x_r, out_y_r;
  logic [5:0]         out_idx_r;
  logic               out_last_r, out_clip_r;

  logic [AW-1:0]      alu_a, alu_b, alu_sum;
  logic               alu_sub, alu_cout;

  logic               in_take, out_load, iter_state, iter_done;
  logic [30:0]        sp_eff;
  logic [36:0]        root_trial;
  logic [34:0]        div_trial;
  logic [34:0]        root_rem;
  logic               cnt_inc, cnt_clip, cnt_zero;

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = (state_r == ST_IDLE);
  assign in_take   = in_valid && (state_r == ST_IDLE);
  assign out_load  = (state_r == ST_EMIT) && (!out_valid_r || !out_stall);

  assign iter_state = (state_r == ST_SQX) || (state_r == ST_SQY) || (state_r == ST_ROOT) ||
                      (state_r == ST_DIVC) || (state_r == ST_DIVX) || (state_r == ST_DIVY);
  assign iter_done  = (cnt_r == 6'd0);

  assign sp_eff     = (spacing_r == 31'd0) ? 31'd1 : spacing_r;
  assign root_trial = {rem_r, acc_r[65:64]};
  assign div_trial  = {rem_r[33:0], root_r[32]};

  // Round the count up, then saturate it
  assign cnt_inc  = exact_r ? (rem_r != 35'd0) : 1'b1;
  assign cnt_zero = (root_r == 33'd0) && !cnt_inc;
  assign cnt_clip = (root_r > MAXQ) || ((root_r == MAXQ) && cnt_inc);

  sdens_addsub #(
    .W (AW)
  ) u_alu (
    .a    (alu_a),
    .b    (alu_b),
    .sub  (alu_sub),
    .sum  (alu_sum),
    .cout (alu_cout)
  );

  // Sequence the passes
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_DX;
      ST_DX:    state_nxt = ST_AX;
      ST_AX:    state_nxt = ST_DY;
      ST_DY:    state_nxt = ST_AY;
      ST_AY:    state_nxt = ST_SQX;
      ST_SQX:   if (iter_done) state_nxt = ST_SQY;
      ST_SQY:   if (iter_done) state_nxt = ST_ROOT;
      ST_ROOT:  if (iter_done) state_nxt = ST_DIVC;
      ST_DIVC:  if (iter_done) state_nxt = ST_COUNT;
      ST_COUNT: state_nxt = cnt_zero ? ST_IDLE : ST_DIVX;
      ST_DIVX:  if (iter_done) state_nxt = ST_SIGNX;
      ST_SIGNX: state_nxt = ST_DIVY;
      ST_DIVY:  if (iter_done) state_nxt = ST_SIGNY;
      ST_SIGNY: state_nxt = ST_EMIT;
      ST_EMIT:  if (out_load && (left_r == CW'(1))) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Drive the shared unit and the datapath for the current state
  always_comb begin
    sx_nxt     = sx_r;
    sy_nxt     = sy_r;
    ex_nxt     = ex_r;
    ey_nxt     = ey_r;
    ax_nxt     = ax_r;
    ay_nxt     = ay_r;
    xneg_nxt   = xneg_r;
    yneg_nxt   = yneg_r;
    acc_nxt    = acc_r;
    mcand_nxt  = mcand_r;
    mpl_nxt    = mpl_r;
    rem_nxt    = rem_r;
    root_nxt   = root_r;
    exact_nxt  = exact_r;
    count_nxt  = count_r;
    left_nxt   = left_r;
    idx_nxt    = idx_r;
    clip_nxt   = clip_r;
    walk_x_nxt = walk_x_r;
    walk_y_nxt = walk_y_r;
    step_x_nxt = step_x_r;
    step_y_nxt = step_y_r;
    root_rem   = root_trial[34:0];
    alu_a      = '0;
    alu_b      = '0;
    alu_sub    = 1'b0;
    cnt_nxt    = (iter_state && !iter_done) ? (cnt_r - 6'd1) : ITER_LAST;

    unique case (state_r) inside
      ST_IDLE: begin
        if (in_take) begin
          sx_nxt = in_start_x;
          sy_nxt = in_start_y;
          ex_nxt = in_end_x;
          ey_nxt = in_end_y;
        end
      end
      ST_DX: begin
        alu_a    = {{35{ex_r[31]}}, ex_r};
        alu_b    = {{35{sx_r[31]}}, sx_r};
        alu_sub  = 1'b1;
        ax_nxt   = alu_sum[32:0];
        xneg_nxt = alu_sum[32];
      end
      ST_AX: begin
        alu_b   = {{34{ax_r[32]}}, ax_r};
        alu_sub = xneg_r;
        ax_nxt  = alu_sum[32:0];
      end
      ST_DY: begin
        alu_a    = {{35{ey_r[31]}}, ey_r};
        alu_b    = {{35{sy_r[31]}}, sy_r};
        alu_sub  = 1'b1;
        ay_nxt   = alu_sum[32:0];
        yneg_nxt = alu_sum[32];
      end
      ST_AY: begin
        alu_b     = {{34{ay_r[32]}}, ay_r};
        alu_sub   = yneg_r;
        ay_nxt    = alu_sum[32:0];
        acc_nxt   = '0;
        mcand_nxt = 66'(ax_r);
        mpl_nxt   = ax_r;
      end
      ST_SQX, ST_SQY: begin
        // shift-add: one multiplier bit per cycle
        alu_a     = AW'(acc_r);
        alu_b     = mpl_r[0] ? AW'(mcand_r) : '0;
        acc_nxt   = alu_sum[65:0];
        mcand_nxt = {mcand_r[64:0], 1'b0};
        mpl_nxt   = {1'b0, mpl_r[32:1]};
        if (iter_done) begin
          if (state_r == ST_SQX) begin
            mcand_nxt = 66'(ay_r);
            mpl_nxt   = ay_r;
          end else begin
            rem_nxt  = '0;
            root_nxt = '0;
          end
        end
      end
      ST_ROOT: begin
        // one root bit per cycle from two radicand bits
        alu_a    = AW'(root_trial);
        alu_b    = AW'({root_r, 2'b01});
        alu_sub  = 1'b1;
        root_rem = alu_cout ? alu_sum[34:0] : root_trial[34:0];
        rem_nxt  = root_rem;
        root_nxt = {root_r[31:0], alu_cout};
        acc_nxt  = {acc_r[63:0], 2'b00};
        if (iter_done) begin
          exact_nxt = (root_rem == 35'd0);
          rem_nxt   = '0;
        end
      end
      ST_DIVC, ST_DIVX, ST_DIVY: begin
        // restoring division, quotient shifts in where the dividend leaves
        alu_a    = AW'(div_trial);
        alu_b    = (state_r == ST_DIVC) ? AW'(sp_eff) : AW'(count_r);
        alu_sub  = 1'b1;
        rem_nxt  = alu_cout ? alu_sum[34:0] : div_trial;
        root_nxt = {root_r[31:0], alu_cout};
      end
      ST_COUNT: begin
        count_nxt  = cnt_clip ? CW'(MAX_POINTS) : (root_r[CW-1:0] + CW'(cnt_inc));
        left_nxt   = count_nxt;
        clip_nxt   = cnt_clip;
        idx_nxt    = '0;
        walk_x_nxt = sx_r;
        walk_y_nxt = sy_r;
        root_nxt   = ax_r;
        rem_nxt    = '0;
      end
      ST_SIGNX: begin
        alu_b      = AW'(root_r);
        alu_sub    = xneg_r;
        step_x_nxt = alu_sum[31:0];
        root_nxt   = ay_r;
        rem_nxt    = '0;
      end
      ST_SIGNY: begin
        alu_b      = AW'(root_r);
        alu_sub    = yneg_r;
        step_y_nxt = alu_sum[31:0];
      end
      ST_EMIT: begin
        // advance the walk as each point is loaded
        if (out_load) begin
          walk_x_nxt = walk_x_r + step_x_r;
          walk_y_nxt = walk_y_r + step_y_r;
          left_nxt   = left_r - CW'(1);
          idx_nxt    = idx_r + 6'd1;
        end
      end
      default: begin
      end
    endcase
  end

  // Hold a loaded point until the receiver takes it
  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      spacing_r   <= SDENS_SPACING_RESET;
      out_valid_r <= 1'b0;
      cnt_r       <= ITER_LAST;
      left_r      <= '0;
      walk_x_r    <= '0;
      walk_y_r    <= '0;
      step_x_r    <= '0;
      step_y_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      left_r      <= left_nxt;
      walk_x_r    <= walk_x_nxt;
      walk_y_r    <= walk_y_nxt;
      step_x_r    <= step_x_nxt;
      step_y_r    <= step_y_nxt;
      if (cfg_valid && cfg_ready) begin
        spacing_r <= cfg_spacing;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    sx_r    <= sx_nxt;
    sy_r    <= sy_nxt;
    ex_r    <= ex_nxt;
    ey_r    <= ey_nxt;
    ax_r    <= ax_nxt;
    ay_r    <= ay_nxt;
    xneg_r  <= xneg_nxt;
    yneg_r  <= yneg_nxt;
    acc_r   <= acc_nxt;
    mcand_r <= mcand_nxt;
    mpl_r   <= mpl_nxt;
    rem_r   <= rem_nxt;
    root_r  <= root_nxt;
    exact_r <= exact_nxt;
    count_r <= count_nxt;
    idx_r   <= idx_nxt;
    clip_r  <= clip_nxt;
    if (out_load) begin
      out_x_r    <= walk_x_r;
      out_y_r    <= walk_y_r;
      out_idx_r  <= idx_r;
      out_last_r <= (left_r == CW'(1));
      out_clip_r <= clip_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_point_x       = out_x_r;
  assign out_point_y       = out_y_r;
  assign out_point_index   = out_idx_r;
  assign out_last_point    = out_last_r;
  assign out_count_clipped = out_clip_r;

  // A new point appears only from the walk
  a_rise_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_EMIT))
    else $error("point appeared outside the walk");

  // The remaining count stays within one to the saturation limit
  a_left_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> ((left_r != '0) && (left_r <= CW'(MAX_POINTS))))
    else $error("remaining point count out of range");

  // Loading the final point ends the walk
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && (left_r == CW'(1))) |=> (state_r == ST_IDLE))
    else $error("walk continued past the last point");

endmodule

/* tb/sv/segment_point_densifier_checker.sv */
`timescale 1ns / 100ps

module segment_point_densifier_checker
  import sdens_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [31:0] in_start_x,
  input  logic signed [31:0] in_start_y,
  input  logic signed [31:0] in_end_x,
  input  logic signed [31:0] in_end_y,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] out_point_x,
  input  logic signed [31:0] out_point_y,
  input  logic [5:0]         out_point_index,
  input  logic               out_last_point,
  input  logic               out_count_clipped,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [30:0]        cfg_spacing,
  output int                 fail_count,
  output int                 pending_points
);

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [5:0]         index;
    logic               last;
    logic               clipped;
  } densified_point_t;

  densified_point_t expected_points[$];
  logic [30:0]      spacing_q = SDENS_SPACING_RESET;
  int               mismatches = 0;
  int               pending_q = 0;

  assign fail_count     = mismatches;
  assign pending_points = pending_q;

  // Work out every point that one segment request produces and queue them
  function automatic void densify_segment(input logic signed [31:0] sx,
                                          input logic signed [31:0] sy,
                                          input logic signed [31:0] ex,
                                          input logic signed [31:0] ey);
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic [32:0]        ax;
    logic [32:0]        ay;
    logic [65:0]        sum_sq;
    logic [33:0]        root;
    logic [33:0]        cand;
    logic [67:0]        trial;
    longint unsigned    span;
    longint unsigned    npts;
    logic [31:0]        walk_x;
    logic [31:0]        walk_y;
    logic [31:0]        step_x;
    logic [31:0]        step_y;
    logic               clipped;
    densified_point_t   pt;
    dx = {ex[31], ex} - {sx[31], sx};
    dy = {ey[31], ey} - {sy[31], sy};
    ax = dx[32] ? 33'(-dx) : 33'(dx);
    ay = dy[32] ? 33'(-dy) : 33'(dy);
    sum_sq = 66'(ax) * 66'(ax) + 66'(ay) * 66'(ay);

    // Integer square root, one bit at a time from the top
    root = '0;
    for (int b = 33; b >= 0; b--) begin
      cand  = root | (34'd1 << b);
      trial = 68'(cand) * 68'(cand);
      if (trial <= 68'(sum_sq)) root = cand;
    end

    // Ceiling of length over spacing; a zero register acts as one
    span = (spacing_q == '0) ? 64'd1 : 64'(spacing_q);
    if (sum_sq == '0)
      npts = 0;
    else if (68'(root) * 68'(root) == 68'(sum_sq))
      npts = (64'(root) + span - 1) / span;
    else
      npts = 64'(root) / span + 1;

    // Saturate the count and flag it
    clipped = (npts > SDENS_MAX_POINTS);
    if (clipped) npts = SDENS_MAX_POINTS;
    if (npts == 0) return;

    step_x = 32'(longint'(dx) / longint'(npts));
    step_y = 32'(longint'(dy) / longint'(npts));
    walk_x = sx;
    walk_y = sy;
    for (int n = 0; n < npts; n++) begin
      pt.x       = walk_x;
      pt.y       = walk_y;
      pt.index   = 6'(n);
      pt.last    = (longint'(n) + 1 == npts);
      pt.clipped = clipped;
      expected_points.insert(expected_points.size(), pt);
      walk_x = walk_x + step_x;
      walk_y = walk_y + step_y;
    end
  endfunction

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Watch all three channels at each edge
  always @(posedge clk) begin : monitor
    densified_point_t want;
    if (!rst_n) begin
      spacing_q = SDENS_SPACING_RESET;
      expected_points.delete();
    end else begin
      // Compare a taken point against the oldest expected one
      if (out_valid && !out_stall) begin
        if (expected_points.size() == 0) begin
          $error("point request (%0d, %0d) index %0d with none expected",
                 out_point_x, out_point_y, out_point_index);
          mismatches++;
        end else begin
          want = expected_points.pop_front();
          check_field("point_x", longint'(want.x), longint'(out_point_x));
          check_field("point_y", longint'(want.y), longint'(out_point_y));
          check_field("point_index", longint'(want.index), longint'(out_point_index));
          check_field("last_point", longint'(want.last), longint'(out_last_point));
          check_field("count_clipped", longint'(want.clipped),
                      longint'(out_count_clipped));
        end
      end
      // Track the spacing register
      if (cfg_valid && cfg_ready) spacing_q = cfg_spacing;
      // Predict the points of a taken segment
      if (in_valid && !in_stall)
        densify_segment(in_start_x, in_start_y, in_end_x, in_end_y);
    end
    pending_q <= expected_points.size();
  end

endmodule

/* tb/sv/segment_point_densifier_unit_test.sv */
`timescale 1ns / 100ps

module segment_point_densifier_unit_test
  import sdens_pkg::*;
();

  localparam logic signed [31:0] COORD_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] COORD_MAX = 32'sh7fff_ffff;
  localparam logic [30:0]        SPACING_MAX = 31'h7fff_ffff;
  localparam int                 SETTLE_CYCLES = 300;
  localparam int                 ITEMS_PER_PHASE = 36;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [31:0] in_start_x = '0;
  logic signed [31:0] in_start_y = '0;
  logic signed [31:0] in_end_x = '0;
  logic signed [31:0] in_end_y = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] out_point_x;
  logic signed [31:0] out_point_y;
  logic [5:0]         out_point_index;
  logic               out_last_point;
  logic               out_count_clipped;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [30:0]        cfg_spacing = SDENS_SPACING_RESET;
  int                 fail_count;
  int                 pending_points;
  int                 send_idle_pct = 0;
  int                 recv_idle_pct = 0;
  logic [30:0]        cur_spacing = SDENS_SPACING_RESET;

  segment_point_densifier_unit i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_start_x       (in_start_x),
    .in_start_y       (in_start_y),
    .in_end_x         (in_end_x),
    .in_end_y         (in_end_y),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_point_x      (out_point_x),
    .out_point_y      (out_point_y),
    .out_point_index  (out_point_index),
    .out_last_point   (out_last_point),
    .out_count_clipped(out_count_clipped),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_spacing      (cfg_spacing)
  );

  segment_point_densifier_checker i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_start_x       (in_start_x),
    .in_start_y       (in_start_y),
    .in_end_x         (in_end_x),
    .in_end_y         (in_end_y),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_point_x      (out_point_x),
    .out_point_y      (out_point_y),
    .out_point_index  (out_point_index),
    .out_last_point   (out_last_point),
    .out_count_clipped(out_count_clipped),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_spacing      (cfg_spacing),
    .fail_count       (fail_count),
    .pending_points   (pending_points)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hold back points at random
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Give up on a hung run
  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Offer one segment request, idling first at random; valid stays high after
  // acceptance until the next call or a drain lowers it
  task automatic send_segment(input logic signed [31:0] sx, input logic signed [31:0] sy,
                              input logic signed [31:0] ex, input logic signed [31:0] ey);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_start_x <= sx;
    in_start_y <= sy;
    in_end_x   <= ex;
    in_end_y   <= ey;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stop offering and wait until every expected point has come
  task automatic drain_points();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_points != 0) @(posedge clk);
  endtask

  // Write the spacing register once the block has gone quiet
  task automatic write_spacing(input logic [30:0] value);
    drain_points();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid   <= 1'b1;
    cfg_spacing <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid   <= 1'b0;
    cur_spacing = value;
  endtask

  function automatic longint rand_offset(input longint lim);
    return lim * (longint'($urandom_range(2000)) - 1000) / 1000;
  endfunction

  function automatic logic [30:0] pick_spacing();
    case ($urandom_range(3))
      0:       return 31'($urandom_range(1, 64));
      1:       return 31'($urandom_range(64, 70000));
      2:       return 31'($urandom_range(1, 32'h7fff_ffff));
      default: return SPACING_MAX;
    endcase
  endfunction

  // Mostly segments a few dozen spacings long, plus wide, zero and exact ones
  task automatic send_random_segment();
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    longint             lx;
    longint             ly;
    int                 kind;
    sx   = $urandom;
    sy   = $urandom;
    kind = $urandom_range(99);
    if (kind < 10) begin
      send_segment(sx, sy, $urandom, $urandom);
    end else if (kind < 16) begin
      send_segment(sx, sy, sx, sy);
    end else if (kind < 28) begin
      // 3-4-5 triangle, length an exact multiple of the spacing
      lx = longint'($urandom_range(1, 16)) * cur_spacing;
      ly = lx;
      if ($urandom_range(1)) lx = -lx;
      if ($urandom_range(1)) ly = -ly;
      send_segment(sx, sy, 32'(longint'(sx) + 3 * lx), 32'(longint'(sy) + 4 * ly));
    end else begin
      lx = longint'($urandom_range(50)) * cur_spacing;
      if (lx > 64'h1_0000_0000) lx = 64'h1_0000_0000;
      send_segment(sx, sy, 32'(longint'(sx) + rand_offset(lx)),
                   32'(longint'(sy) + rand_offset(lx)));
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed segments at the reset spacing
    send_segment(0, 0, 0, 0);
    send_segment(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN);
    send_segment(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
    send_segment(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN);
    send_segment(0, 0, 3277, 0);
    send_segment(0, 0, 3278, 0);
    send_segment(0, 0, 0, -32770);
    send_segment(100, 200, 100 + 12 * 3277, 200 + 16 * 3277);
    send_segment(0, 0, 1, 1);
    send_segment(0, 0, 64 * 3277, 0);
    send_segment(0, 0, 64 * 3277 + 1, 0);
    send_segment(5000, -7000, -90000, 40000);
    // Hold off until the block has emitted everything
    drain_points();
    send_segment(-1, -1, -70000, 33000);

    // Smallest spacing
    write_spacing(31'd1);
    send_segment(0, 0, 1, 0);
    send_segment(0, 0, 2, 0);
    send_segment(10, 10, -53, 10);
    send_segment(0, 0, 30, 40);

    // A zero register behaves as one
    write_spacing(31'd0);
    send_segment(0, 0, 5, 0);
    send_segment(0, 0, -3, 4);

    // Largest spacing
    write_spacing(SPACING_MAX);
    send_segment(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
    send_segment(COORD_MIN, 0, COORD_MAX, 0);
    send_segment(COORD_MAX, 0, COORD_MIN, COORD_MAX);
    send_segment(0, 0, 32'sh7fff_ffff, 0);

    // Random phases: receiver-heavy idling, sender-heavy, then none
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 30;
          recv_idle_pct = 62;
        end
        1: begin
          send_idle_pct = 62;
          recv_idle_pct = 30;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      write_spacing(pick_spacing());
      for (int item = 0; item < ITEMS_PER_PHASE; item++) begin
        if (item == ITEMS_PER_PHASE / 4) drain_points();
        if (item == ITEMS_PER_PHASE / 2) write_spacing(pick_spacing());
        send_random_segment();
      end
    end

    // Let the last segment finish, then give the verdict
    drain_points();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_points == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
